/* rtl/core/bara_pkg.sv */
// Package for the bit array range access block: status codes, controller
// states, command/status bundles and the range mask helper.
// No dependencies; imported by all modules under rtl/core.
package bara_pkg;

  localparam int DataW     = 32;
  localparam int PosIdxW   = 15;
  localparam int LenW      = 6;
  localparam int InTdataW  = 64;
  localparam int MaxRange  = 32;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ORDER = 2'd1,
    STAT_LONG  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_DIV3,
    ST_DIV4,
    ST_READ,
    ST_MOD,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic load;
    logic div1;
    logic div2;
    logic div3;
    logic div4;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic err;
    logic more;
    logic out_free;
  } sts_t;

  function automatic logic [DataW-1:0] range_mask(input logic [LenW-1:0] n);
    logic [DataW-1:0] m;
    if (n >= LenW'(MaxRange)) begin
      m = '1;
    end else begin
      m = (DataW'(1) << n) - DataW'(1);
    end
    return m;
  endfunction

endpackage

/* rtl/core/bara_ctrl.sv */
// Controller state machine of the bit array range access block.
// Depends on bara_pkg; drives the command bundle of bara_dp.
module bara_ctrl
  import bara_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIV1;
      end
      ST_DIV1: begin
        state_d = sts_i.err ? ST_FINISH : ST_DIV2;
      end
      ST_DIV2:   state_d = ST_DIV3;
      ST_DIV3:   state_d = ST_DIV4;
      ST_DIV4:   state_d = ST_READ;
      ST_READ:   state_d = ST_MOD;
      ST_MOD: begin
        if (!sts_i.more) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV1:   cmd_o.div1 = 1'b1;
      ST_DIV2:   cmd_o.div2 = 1'b1;
      ST_DIV3:   cmd_o.div3 = 1'b1;
      ST_DIV4:   cmd_o.div4 = 1'b1;
      ST_READ:   cmd_o = '0;
      ST_MOD:    cmd_o.step = 1'b1;
      ST_FINISH: cmd_o.finish = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

/* rtl/core/bara_dp.sv */
// Datapath of the bit array range access block: request registers,
// index division, word store, merge logic and output register.
// Depends on bara_pkg; driven by bara_ctrl.
module bara_dp
  import bara_pkg::*;
#(
  parameter int STORE_WORDS = 1024,
  parameter int WORD_BITS   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 action_i,
  input  logic [PosIdxW-1:0]   first_bit_i,
  input  logic [PosIdxW-1:0]   last_bit_i,
  input  logic [DataW-1:0]     value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DataW-1:0]     read_data_o,
  output logic [1:0]           status_o
);

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int PW = $clog2(WORD_BITS);
  // Reciprocals scaled by 2^16; floor keeps the quotient estimate low by at most one.
  localparam int RecipBits = 65536 / WORD_BITS;
  localparam int RecipWords = 65536 / STORE_WORDS;

  logic [WORD_BITS-1:0] mem [STORE_WORDS];
  logic [WORD_BITS-1:0] mem_q;

  logic [AW-1:0]        clr_addr_q;
  logic                 act_q;
  logic [PosIdxW-1:0]   first_q;
  logic [DataW-1:0]     val_q;
  status_e              st_q, st_d;
  logic [LenW-1:0]      rem_q, done_q;
  logic [DataW-1:0]     prod_q;
  logic [15:0]          wq_q;
  logic [PW-1:0]        pos_q;
  logic [AW-1:0]        widx_q;
  logic [DataW-1:0]     rdata_q;
  logic                 out_valid_q;
  logic [DataW-1:0]     out_data_q;
  logic [1:0]           out_status_q;

  logic [15:0]          len;
  logic [15:0]          qe, qw, r1;
  logic [DataW-1:0]     t2, r2;
  logic [LenW-1:0]      avail, n;
  logic [DataW-1:0]     mask_n, fmask, ext, ins;
  logic [WORD_BITS-1:0] new_word;
  logic [AW-1:0]        widx_nx, raddr, waddr;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;

  // Request classification at accept time.
  always_comb begin
    len  = 16'(last_bit_i) - 16'(first_bit_i) + 16'd1;
    st_d = STAT_OK;
    if (first_bit_i > last_bit_i) begin
      st_d = STAT_ORDER;
    end else if (len > 16'(MaxRange)) begin
      st_d = STAT_LONG;
    end
  end

  // Division remainders and the per-word merge.
  always_comb begin
    qe = prod_q[31:16];
    qw = qe * 16'(WORD_BITS);
    r1 = 16'(first_q) - qw;
    t2 = DataW'(prod_q[31:16]) * DataW'(STORE_WORDS);
    r2 = DataW'(wq_q) - t2;

    avail  = LenW'(WORD_BITS) - LenW'(pos_q);
    n      = (rem_q < avail) ? rem_q : avail;
    mask_n = range_mask(n);
    fmask  = mask_n << pos_q;
    ext    = ((DataW'(mem_q) >> pos_q) & mask_n) << done_q;
    ins    = ((val_q >> done_q) & mask_n) << pos_q;
    new_word = (mem_q & ~fmask[WORD_BITS-1:0]) | ins[WORD_BITS-1:0];

    widx_nx = (widx_q == AW'(STORE_WORDS - 1)) ? '0 : widx_q + 1'b1;
    raddr   = cmd_i.step ? widx_nx : widx_q;
    we      = cmd_i.clr || (cmd_i.step && act_q);
    waddr   = cmd_i.clr ? clr_addr_q : widx_q;
    wdata   = cmd_i.clr ? '0 : new_word;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_i;
      first_q <= first_bit_i;
      val_q   <= value_i;
      st_q    <= st_d;
      rem_q   <= len[LenW-1:0];
      done_q  <= '0;
      rdata_q <= '0;
    end
    if (cmd_i.div1) begin
      prod_q <= DataW'(first_q) * DataW'(RecipBits);
    end
    if (cmd_i.div2) begin
      if (r1 >= 16'(WORD_BITS)) begin
        wq_q  <= qe + 16'd1;
        pos_q <= PW'(r1 - 16'(WORD_BITS));
      end else begin
        wq_q  <= qe;
        pos_q <= PW'(r1);
      end
    end
    if (cmd_i.div3) begin
      prod_q <= DataW'(wq_q) * DataW'(RecipWords);
    end
    if (cmd_i.div4) begin
      if (r2 >= DataW'(STORE_WORDS)) begin
        widx_q <= AW'(r2 - DataW'(STORE_WORDS));
      end else begin
        widx_q <= AW'(r2);
      end
    end
    if (cmd_i.step) begin
      rem_q  <= rem_q - n;
      done_q <= done_q + n;
      pos_q  <= '0;
      widx_q <= widx_nx;
      if (!act_q) begin
        rdata_q <= rdata_q | ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q   <= rdata_q;
      out_status_q <= st_q;
    end
  end

  assign sts_o.clr_last = (clr_addr_q == AW'(STORE_WORDS - 1));
  assign sts_o.err      = (st_q != STAT_OK);
  assign sts_o.more     = ((rem_q - n) != '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = out_status_q;

  // A merge step always has bits left to move.
  a_step_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> rem_q != '0)
    else $error("merge step with no bits remaining");

  // The bit position from the first division lies inside a word.
  a_pos_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div2) |-> 32'(pos_q) < WORD_BITS)
    else $error("bit position beyond word width");

  // The word index after reduction stays inside the store.
  a_widx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> 32'(widx_q) < STORE_WORDS)
    else $error("word index beyond store");

  // A rejected request reports zero data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && st_q != STAT_OK) |=> out_data_q == '0)
    else $error("nonzero data on rejected request");

endmodule

/* rtl/core/bit_array_range_access.sv */
// Flow: a rejected request goes from IDLE through DIV1 to FINISH; an accepted
// range goes through the two-stage index division (DIV1 to DIV4), READ, one MOD
// step per word touched (1 or 2 at 32-bit words, up to 5 at 8-bit words; a
// read-modify-write for writes) and FINISH, which waits for a free output.
// A new beat is taken only in IDLE, once the previous request is finished.
// Reset: asynchronous; a clearing pass then zeroes every word of the store.
module bit_array_range_access
  import bara_pkg::*;
#(
  parameter int STORE_WORDS = 1024,
  parameter int WORD_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [14:0] first_bit, [29:15] last_bit, [61:30] value, [63:62] zero
  input  logic [InTdataW-1:0] s_axis_tdata,
  // [0] action
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] read_data
  output logic [DataW-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [1:0]          m_axis_tuser
);

  cmd_t cmd;
  sts_t sts;

  bara_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bara_dp #(
    .STORE_WORDS (STORE_WORDS),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (s_axis_tuser),
    .first_bit_i (s_axis_tdata[14:0]),
    .last_bit_i  (s_axis_tdata[29:15]),
    .value_i     (s_axis_tdata[61:30]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .read_data_o (m_axis_tdata),
    .status_o    (m_axis_tuser)
  );

endmodule
